// File: sv/sobel_pkg.sv
// ----------------------------------------------------------------------------
// Sobel edge magnitude package
// Shared widths, constants and register indexes for the Sobel edge unit.
// ----------------------------------------------------------------------------
package sobel_pkg;

	// Line store geometry.
	localparam int MAX_WIDTH  = 2048;
	localparam int MAX_HEIGHT = 4096;
	localparam int LINE_AW    = $clog2(MAX_WIDTH);

	// Field widths.
	localparam int PIX_W  = 8;
	localparam int COL_W  = 11;
	localparam int ROW_W  = 12;
	localparam int CFGW_W = 12;
	localparam int CFGH_W = 13;

	// Gray conversion: (299r + 587g + 114b) / 1000, done as a multiply by
	// the reciprocal 2^28/1000 rounded up; exact for all sums below 493000.
	localparam int GRAY_WR     = 299;
	localparam int GRAY_WG     = 587;
	localparam int GRAY_WB     = 114;
	localparam int GSUM_W      = 18;
	localparam int GRAY_RECIP  = 268436;
	localparam int GRAY_SHIFT  = 28;
	localparam int GPROD_W     = 37;

	// Gradient and magnitude widths.
	localparam int GRAD_W = 12;
	localparam int SQ_W   = 21;
	localparam int SQ_SAT = 65536;

	// Configuration register indexes.
	localparam logic [0:0] CFG_WIDTH  = 1'b0;
	localparam logic [0:0] CFG_HEIGHT = 1'b1;

	localparam logic [CFGW_W-1:0] WIDTH_RESET  = 12'd640;
	localparam logic [CFGH_W-1:0] HEIGHT_RESET = 13'd480;

endpackage

// File: sv/sobel_isqrt.sv
// ----------------------------------------------------------------------------
// Sobel integer square root
// Bit-serial floor square root of the squared gradient sum, clamped to 255.
// ----------------------------------------------------------------------------
module sobel_isqrt import sobel_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [SQ_W-1:0]   radicand,
	output logic              done,
	output logic [PIX_W-1:0]  root
);

	logic [SQ_W-1:0]  rad_q;
	logic [PIX_W-1:0] m_q;
	logic [2:0]       bit_q;
	logic             busy_q;
	logic             sat_q;
	logic             done_q;
	logic [PIX_W-1:0] trial;
	logic [2*PIX_W-1:0] trial_sq;

	// One result bit is decided per cycle, most significant first.
	assign trial    = m_q | (PIX_W'(1) << bit_q);
	assign trial_sq = trial * trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			bit_q  <= '0;
			m_q    <= '0;
			sat_q  <= 1'b0;
			rad_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				rad_q  <= radicand;
				sat_q  <= (radicand >= SQ_W'(SQ_SAT));
				m_q    <= '0;
				bit_q  <= 3'd7;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (SQ_W'(trial_sq) <= rad_q) begin
					m_q <= trial;
				end
				if (bit_q == 3'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					bit_q <= bit_q - 3'd1;
				end
			end
		end
	end

	assign done = done_q;
	assign root = sat_q ? {PIX_W{1'b1}} : m_q;

endmodule

// File: sv/sobel_edge_magnitude_unit.sv
// ----------------------------------------------------------------------------
// Sobel edge magnitude unit
// Streaming 3x3 Sobel gradient magnitude over an RGB raster.
// ----------------------------------------------------------------------------
// Pixels enter on the s_ group in raster order, one transaction per pixel.
// Each pixel is turned into gray, pushed through two line memories and a
// 3x3 window, and each input causes zero to three result transactions on
// the m_ group: the pixel up and to the left, the right column at row end,
// and the pixel itself on the last row. m_tlast marks the last result of
// an input and m_tuser the final result of the frame.
// An input passes through the read and gray steps and then the emit
// step, which loads its results one at a time into the output register;
// an input that needs a gradient passes through the gradient, square and
// bit-serial square root steps between gray and emit. One pixel is worked
// on at a time; the output register lets the next pixel in while the last
// result still waits for m_tready, and a stalled receiver holds the block
// in its emit step. Reset sets width 640 and height 480 and starts a new
// frame at (0, 0); a write on the cfg_ group also restarts the frame. The
// line memories are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_unit import sobel_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [23:0]       s_tdata,   // red[7:0], green[15:8], blue[23:16]
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [31:0]       m_tdata,   // out_col[10:0], out_row[22:11], edge_value[30:23]
	output logic              m_tlast,
	output logic [0:0]        m_tuser,   // frame_done[0]
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [0:0]        cfg_addr,
	input  logic [CFGH_W-1:0] cfg_wdata
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_GRAY,
		ST_GRAD,
		ST_SQR,
		ST_ROOT,
		ST_EMIT
	} state_t;

	state_t state_q;

	logic [CFGW_W-1:0] width_q;
	logic [CFGH_W-1:0] height_q;
	logic [COL_W-1:0]  col_cnt_q;
	logic [ROW_W-1:0]  row_cnt_q;
	logic [COL_W-1:0]  pix_col_q;
	logic [ROW_W-1:0]  pix_row_q;
	logic [2:0]        pend_q;
	logic              inner_q;
	logic              frame_end_q;
	logic [PIX_W-1:0]  mag_q;

	logic              out_valid_q;
	logic [COL_W-1:0]  out_col_q;
	logic [ROW_W-1:0]  out_row_q;
	logic [PIX_W-1:0]  out_edge_q;
	logic              out_last_q;
	logic              out_done_q;

	logic [PIX_W-1:0] mem_upper [MAX_WIDTH];
	logic [PIX_W-1:0] mem_lower [MAX_WIDTH];
	logic [PIX_W-1:0] rd_upper_q;
	logic [PIX_W-1:0] rd_lower_q;
	logic [PIX_W-1:0] win_q [3][3];

	logic [GSUM_W-1:0]  gsum_q;
	logic [GPROD_W-1:0] gprod_q;
	logic signed [GRAD_W-1:0] gx_q;
	logic signed [GRAD_W-1:0] gy_q;

	logic [CFGW_W-1:0] w_eff;
	logic [CFGH_W-1:0] h_eff;
	logic              wrap;
	logic [COL_W-1:0]  c_eff;
	logic [ROW_W-1:0]  r_eff;
	logic              accept;
	logic              last_col;
	logic              last_row;
	logic [COL_W-1:0]  col_next;
	logic [ROW_W-1:0]  row_next;
	logic [PIX_W-1:0]  red;
	logic [PIX_W-1:0]  green;
	logic [PIX_W-1:0]  blue;
	logic [GSUM_W-1:0] gray_sum;
	logic [PIX_W-1:0]  gray;
	logic [9:0]        gx_pos;
	logic [9:0]        gx_neg;
	logic [9:0]        gy_pos;
	logic [9:0]        gy_neg;
	logic signed [2*GRAD_W-1:0] gx_sq;
	logic signed [2*GRAD_W-1:0] gy_sq;
	logic [SQ_W-1:0]   sq_sum;
	logic              root_start;
	logic              root_done;
	logic [PIX_W-1:0]  root;
	logic [COL_W-1:0]  emit_col;
	logic [ROW_W-1:0]  emit_row;
	logic [PIX_W-1:0]  emit_edge;
	logic [2:0]        emit_rest;
	logic              out_free;
	logic              emit_load;

	// Effective frame size: zero acts as one, oversize saturates.
	always_comb begin
		if (width_q == '0) begin
			w_eff = CFGW_W'(1);
		end else if (width_q > CFGW_W'(MAX_WIDTH)) begin
			w_eff = CFGW_W'(MAX_WIDTH);
		end else begin
			w_eff = width_q;
		end
		if (height_q == '0) begin
			h_eff = CFGH_W'(1);
		end else if (height_q > CFGH_W'(MAX_HEIGHT)) begin
			h_eff = CFGH_W'(MAX_HEIGHT);
		end else begin
			h_eff = height_q;
		end
	end

	// Position of the incoming pixel and the raster position after it.
	assign wrap     = ({1'b0, col_cnt_q} >= w_eff) || ({1'b0, row_cnt_q} >= h_eff);
	assign c_eff    = wrap ? '0 : col_cnt_q;
	assign r_eff    = wrap ? '0 : row_cnt_q;
	assign last_col = ({1'b0, c_eff} == (w_eff - CFGW_W'(1)));
	assign last_row = ({1'b0, r_eff} == (h_eff - CFGH_W'(1)));
	assign col_next = last_col ? '0 : (c_eff + COL_W'(1));
	assign row_next = !last_col ? r_eff : (last_row ? '0 : (r_eff + ROW_W'(1)));

	// A register write takes priority over a pixel in the same cycle.
	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE) && !cfg_valid;
	assign cfg_ready = 1'b1;

	// Weighted gray sum and its division by 1000 through the reciprocal.
	assign red      = s_tdata[7:0];
	assign green    = s_tdata[15:8];
	assign blue     = s_tdata[23:16];
	assign gray_sum = GSUM_W'(red) * GSUM_W'(GRAY_WR) + GSUM_W'(green) * GSUM_W'(GRAY_WG)
		+ GSUM_W'(blue) * GSUM_W'(GRAY_WB);
	assign gray     = gprod_q[GRAY_SHIFT +: PIX_W];

	// Sobel kernels over the window, row 0 on top and column 2 newest.
	assign gx_pos = 10'(win_q[0][2]) + 10'({win_q[1][2], 1'b0}) + 10'(win_q[2][2]);
	assign gx_neg = 10'(win_q[0][0]) + 10'({win_q[1][0], 1'b0}) + 10'(win_q[2][0]);
	assign gy_pos = 10'(win_q[2][0]) + 10'({win_q[2][1], 1'b0}) + 10'(win_q[2][2]);
	assign gy_neg = 10'(win_q[0][0]) + 10'({win_q[0][1], 1'b0}) + 10'(win_q[0][2]);

	assign gx_sq  = gx_q * gx_q;
	assign gy_sq  = gy_q * gy_q;
	assign sq_sum = SQ_W'(gx_sq) + SQ_W'(gy_sq);

	assign root_start = (state_q == ST_SQR);

	sobel_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (root_start),
		.radicand (sq_sum),
		.done     (root_done),
		.root     (root)
	);

	// Datapath registers along the item's steps.
	always_ff @(posedge clk) begin
		if (accept) begin
			gsum_q <= gray_sum;
		end
		if (state_q == ST_READ) begin
			gprod_q <= GPROD_W'(gsum_q) * GPROD_W'(GRAY_RECIP);
		end
		if (state_q == ST_GRAD) begin
			gx_q <= $signed({2'b00, gx_pos}) - $signed({2'b00, gx_neg});
			gy_q <= $signed({2'b00, gy_pos}) - $signed({2'b00, gy_neg});
		end
	end

	// Line memories: read at accept, rows rotate upward on write back.
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_upper_q <= mem_upper[LINE_AW'(c_eff)];
			rd_lower_q <= mem_lower[LINE_AW'(c_eff)];
		end
		if (state_q == ST_READ) begin
			mem_upper[LINE_AW'(pix_col_q)] <= rd_lower_q;
		end
		if (state_q == ST_GRAY) begin
			mem_lower[LINE_AW'(pix_col_q)] <= gray;
		end
	end

	// Window shift fed by the memories and the gray value; a register write clears it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					win_q[i][j] <= '0;
				end
			end
		end else if (cfg_valid) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					win_q[i][j] <= '0;
				end
			end
		end else if (state_q == ST_READ) begin
			for (int i = 0; i < 3; i++) begin
				win_q[i][0] <= win_q[i][1];
				win_q[i][1] <= win_q[i][2];
			end
			win_q[0][2] <= rd_upper_q;
			win_q[1][2] <= rd_lower_q;
		end else if (state_q == ST_GRAY) begin
			win_q[2][2] <= gray;
		end
	end

	// Next pending result, in the order up-left, row end, last row.
	always_comb begin
		if (pend_q[0]) begin
			emit_col  = pix_col_q - COL_W'(1);
			emit_row  = pix_row_q - ROW_W'(1);
			emit_edge = inner_q ? mag_q : '0;
			emit_rest = pend_q & 3'b110;
		end else if (pend_q[1]) begin
			emit_col  = COL_W'(w_eff - CFGW_W'(1));
			emit_row  = pix_row_q - ROW_W'(1);
			emit_edge = '0;
			emit_rest = pend_q & 3'b100;
		end else begin
			emit_col  = pix_col_q;
			emit_row  = pix_row_q;
			emit_edge = '0;
			emit_rest = 3'b000;
		end
	end

	assign out_free  = !out_valid_q || m_tready;
	assign emit_load = (state_q == ST_EMIT) && (pend_q != 3'b000) && out_free;

	// Sequencer, configuration registers, raster counters and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			width_q     <= WIDTH_RESET;
			height_q    <= HEIGHT_RESET;
			col_cnt_q   <= '0;
			row_cnt_q   <= '0;
			pix_col_q   <= '0;
			pix_row_q   <= '0;
			pend_q      <= '0;
			inner_q     <= 1'b0;
			frame_end_q <= 1'b0;
			mag_q       <= '0;
			out_valid_q <= 1'b0;
			out_col_q   <= '0;
			out_row_q   <= '0;
			out_edge_q  <= '0;
			out_last_q  <= 1'b0;
			out_done_q  <= 1'b0;
		end else begin
			if (emit_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						pix_col_q   <= c_eff;
						pix_row_q   <= r_eff;
						col_cnt_q   <= col_next;
						row_cnt_q   <= row_next;
						pend_q      <= {last_row, (r_eff != '0) && last_col,
							(r_eff != '0) && (c_eff != '0)};
						inner_q     <= (r_eff >= ROW_W'(2)) && (c_eff >= COL_W'(2));
						frame_end_q <= last_col && last_row;
						state_q     <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_GRAY;
				end
				ST_GRAY: begin
					state_q <= (pend_q[0] && inner_q) ? ST_GRAD : ST_EMIT;
				end
				ST_GRAD: begin
					state_q <= ST_SQR;
				end
				ST_SQR: begin
					state_q <= ST_ROOT;
				end
				ST_ROOT: begin
					if (root_done) begin
						mag_q   <= root;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (pend_q == 3'b000) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						out_col_q   <= emit_col;
						out_row_q   <= emit_row;
						out_edge_q  <= emit_edge;
						out_last_q  <= (emit_rest == 3'b000);
						out_done_q  <= (emit_rest == 3'b000) && frame_end_q;
						pend_q      <= emit_rest;
						if (emit_rest == 3'b000) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			// A register write restarts the frame.
			if (cfg_valid) begin
				unique case (cfg_addr)
					CFG_WIDTH:  width_q  <= cfg_wdata[CFGW_W-1:0];
					CFG_HEIGHT: height_q <= cfg_wdata;
					default:    width_q  <= width_q;
				endcase
				col_cnt_q <= '0;
				row_cnt_q <= '0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_edge_q, out_row_q, out_col_q};
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_done_q;

endmodule

// File: tb/tb_sobel_edge_magnitude_unit.sv
// ----------------------------------------------------------------------------
// Sobel edge magnitude unit testbench
// Streams RGB pixels through the unit under several frame sizes, predicts
// every gradient result from a behavioral copy of the line stores and the
// 3x3 window, and compares each result transaction field by field.
// ----------------------------------------------------------------------------
module tb_sobel_edge_magnitude_unit;
	import sobel_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS  = 455;
	localparam int DIR_ROWS      = 26;
	localparam int SETTLE_CYCLES = 40;
	localparam int TAIL_CYCLES   = 40;
	localparam int QUIET_LIMIT   = 2000;

	// One output pixel as it travels on the master side.
	typedef struct packed {
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic [PIX_W-1:0] mag;
		logic             last;
		logic             done;
	} edge_result_t;

	typedef enum logic [1:0] {ROW_PIXEL, ROW_CONFIG, ROW_PAUSE} row_kind_t;
	typedef enum logic [1:0] {CHK_PREDICT, CHK_NONE, CHK_ONE} row_check_t;

	// One line of the directed stimulus table.
	typedef struct packed {
		row_kind_t        kind;
		logic [0:0]       addr;
		logic [12:0]      value;
		logic [23:0]      pixel;
		row_check_t       chk;
		edge_result_t     res;
	} stim_row_t;

	localparam edge_result_t NO_RESULT = '0;

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [23:0]       s_tdata;   // red[7:0], green[15:8], blue[23:16]
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [31:0]       m_tdata;   // out_col[10:0], out_row[22:11], edge_value[30:23]
	logic              m_tlast;
	logic [0:0]        m_tuser;   // frame_done[0]
	logic              cfg_valid;
	logic              cfg_ready;
	logic [0:0]        cfg_addr;
	logic [CFGH_W-1:0] cfg_wdata;

	sobel_edge_magnitude_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	// Behavioral image of the unit: registers, raster position, line stores
	// and the 3x3 gray window.
	logic [CFGW_W-1:0] reg_width;
	logic [CFGH_W-1:0] reg_height;
	int unsigned       col_pos;
	int unsigned       row_pos;
	logic [7:0]        line_upper [MAX_WIDTH];
	logic [7:0]        line_lower [MAX_WIDTH];
	logic [7:0]        win [3][3];

	// Results caused by the latest pixel, and all results still owed.
	edge_result_t      pred_res [3];
	int                pred_n;
	edge_result_t      pending_edges [$];

	int unsigned       error_count = 0;
	int unsigned       quiet_cycles = 0;
	int unsigned       src_idle_pct;
	int unsigned       snk_stall_pct;
	edge_result_t      got_res;
	edge_result_t      want_res;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic int unsigned frame_width();
		if (reg_width == 0)
			return 1;
		if (reg_width > MAX_WIDTH)
			return MAX_WIDTH;
		return reg_width;
	endfunction

	function automatic int unsigned frame_height();
		if (reg_height == 0)
			return 1;
		if (reg_height > MAX_HEIGHT)
			return MAX_HEIGHT;
		return reg_height;
	endfunction

	// Sobel magnitude of the current window, floored square root clamped to 255.
	function automatic logic [7:0] sobel_mag();
		int gx, gy, s, m, v;
		gx = (int'(win[0][2]) + 2 * int'(win[1][2]) + int'(win[2][2]))
			- (int'(win[0][0]) + 2 * int'(win[1][0]) + int'(win[2][0]));
		gy = (int'(win[2][0]) + 2 * int'(win[2][1]) + int'(win[2][2]))
			- (int'(win[0][0]) + 2 * int'(win[0][1]) + int'(win[0][2]));
		s = gx * gx + gy * gy;
		if (s >= 65536)
			return 8'd255;
		m = 0;
		for (v = 1; v < 256; v++)
			if (v * v <= s)
				m = v;
		return m[7:0];
	endfunction

	task automatic add_result(input int unsigned x, input int unsigned y,
			input logic [7:0] mag);
		pred_res[pred_n].col  = x[COL_W-1:0];
		pred_res[pred_n].row  = y[ROW_W-1:0];
		pred_res[pred_n].mag  = mag;
		pred_res[pred_n].last = 1'b0;
		pred_res[pred_n].done = 1'b0;
		pred_n++;
	endtask

	// Advance the behavioral image by one pixel and list the results it causes.
	task automatic predict_pixel(input logic [23:0] px);
		int unsigned fw, fh, c, r, x, y;
		logic [7:0]  gray, top, mid;
		bit          inner;
		int          k;
		fw = frame_width();
		fh = frame_height();
		c = col_pos;
		r = row_pos;
		if (c >= fw || r >= fh) begin
			c = 0;
			r = 0;
		end
		gray = 8'((299 * int'(px[7:0]) + 587 * int'(px[15:8]) + 114 * int'(px[23:16]))
			/ 1000);
		top = line_upper[c];
		mid = line_lower[c];
		line_upper[c] = mid;
		line_lower[c] = gray;
		for (k = 0; k < 3; k++) begin
			win[k][0] = win[k][1];
			win[k][1] = win[k][2];
		end
		win[0][2] = top;
		win[1][2] = mid;
		win[2][2] = gray;

		// Up-left neighbor, right column at row end, then the last row.
		pred_n = 0;
		if (r >= 1 && c >= 1) begin
			x = c - 1;
			y = r - 1;
			inner = x >= 1 && x + 2 <= fw && y >= 1 && y + 2 <= fh;
			add_result(x, y, inner ? sobel_mag() : 8'd0);
		end
		if (r >= 1 && c == fw - 1)
			add_result(fw - 1, r - 1, 8'd0);
		if (r == fh - 1)
			add_result(c, r, 8'd0);
		if (pred_n > 0) begin
			pred_res[pred_n-1].last = 1'b1;
			pred_res[pred_n-1].done = (c == fw - 1 && r == fh - 1);
		end

		if (c + 1 < fw) begin
			col_pos = c + 1;
			row_pos = r;
		end else begin
			col_pos = 0;
			row_pos = (r + 1 < fh) ? r + 1 : 0;
		end
	endtask

	// Hold the sender until every owed result has been taken.
	task automatic wait_drained();
		if (pending_edges.size() != 0) begin
			s_tvalid <= 1'b0;
			while (pending_edges.size() != 0)
				@(posedge clk);
		end
	endtask

	// Offer one pixel, with random idle cycles first, and log what it owes.
	task automatic send_pixel(input logic [23:0] px, input row_check_t chk,
			input edge_result_t res);
		int k;
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= px;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predict_pixel(px);
		if (chk == CHK_PREDICT) begin
			for (k = 0; k < pred_n; k++)
				pending_edges.push_back(pred_res[k]);
		end else if (chk == CHK_ONE) begin
			pending_edges.push_back(res);
		end
	endtask

	// Register write on an idle unit; any write restarts the frame.
	task automatic write_reg(input logic [0:0] addr, input logic [12:0] val);
		int i, j;
		wait_drained();
		s_tvalid <= 1'b0;
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_addr  <= addr;
		cfg_wdata <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		if (addr == CFG_WIDTH)
			reg_width = val[CFGW_W-1:0];
		else
			reg_height = val;
		col_pos = 0;
		row_pos = 0;
		for (i = 0; i < 3; i++)
			for (j = 0; j < 3; j++)
				win[i][j] = '0;
	endtask

	// Receiver: random stalls, and every result transaction checked in order.
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= snk_stall_pct);
		if (arst_n && m_tvalid && m_tready) begin
			got_res.col  = m_tdata[10:0];
			got_res.row  = m_tdata[22:11];
			got_res.mag  = m_tdata[30:23];
			got_res.last = m_tlast;
			got_res.done = m_tuser[0];
			if (pending_edges.size() == 0) begin
				$error("unexpected result at col %0d row %0d", got_res.col, got_res.row);
				error_count++;
			end else begin
				want_res = pending_edges.pop_front();
				if (got_res.col != want_res.col) begin
					$error("out_col: expected %0d, got %0d", want_res.col, got_res.col);
					error_count++;
				end
				if (got_res.row != want_res.row) begin
					$error("out_row: expected %0d, got %0d", want_res.row, got_res.row);
					error_count++;
				end
				if (got_res.mag != want_res.mag) begin
					$error("edge_value: expected %0d, got %0d", want_res.mag, got_res.mag);
					error_count++;
				end
				if (got_res.last != want_res.last) begin
					$error("run_last: expected %0d, got %0d", want_res.last, got_res.last);
					error_count++;
				end
				if (got_res.done != want_res.done) begin
					$error("frame_done: expected %0d, got %0d", want_res.done, got_res.done);
					error_count++;
				end
			end
		end
	end

	// Watchdog: too long without any transaction on any channel.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("** sobel_edge_magnitude_unit: FAILED **");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		stim_row_t   directed [DIR_ROWS];
		stim_row_t   row_e;
		int          idx, i, j, shape, sel, rand_items;
		int unsigned area, npix;
		logic [12:0] wv, hv;
		logic [23:0] px;

		// After reset at 640x480, the first pixel owes nothing.
		directed[0]  = '{ROW_PIXEL, CFG_WIDTH, 13'd0, 24'hFFFFFF, CHK_NONE, NO_RESULT};
		// Zero width and height act as a 1x1 frame: one result, frame done.
		directed[1]  = '{ROW_CONFIG, CFG_WIDTH, 13'd0, 24'h0, CHK_NONE, NO_RESULT};
		directed[2]  = '{ROW_CONFIG, CFG_HEIGHT, 13'd0, 24'h0, CHK_NONE, NO_RESULT};
		directed[3]  = '{ROW_PIXEL, CFG_WIDTH, 13'd0, 24'h0000FF, CHK_ONE,
			'{11'd0, 12'd0, 8'd0, 1'b1, 1'b1}};
		directed[4]  = '{ROW_PIXEL, CFG_WIDTH, 13'd0, 24'h00FF00, CHK_ONE,
			'{11'd0, 12'd0, 8'd0, 1'b1, 1'b1}};
		// Oversized width saturates; a single row emits every pixel as it comes.
		directed[5]  = '{ROW_CONFIG, CFG_WIDTH, 13'h0FFF, 24'h0, CHK_NONE, NO_RESULT};
		directed[6]  = '{ROW_CONFIG, CFG_HEIGHT, 13'd1, 24'h0, CHK_NONE, NO_RESULT};
		directed[7]  = '{ROW_PIXEL, CFG_WIDTH, 13'd0, 24'hFF0000, CHK_ONE,
			'{11'd0, 12'd0, 8'd0, 1'b1, 1'b0}};
		directed[8]  = '{ROW_PIXEL, CFG_WIDTH, 13'd0, 24'h000000, CHK_ONE,
			'{11'd1, 12'd0, 8'd0, 1'b1, 1'b0}};
		// One column and an oversized height: each row end emits the row above.
		directed[9]  = '{ROW_CONFIG, CFG_WIDTH, 13'd1, 24'h0, CHK_NONE, NO_RESULT};
		directed[10] = '{ROW_CONFIG, CFG_HEIGHT, 13'h1FFF, 24'h0, CHK_NONE, NO_RESULT};
		directed[11] = '{ROW_PIXEL, CFG_WIDTH, 13'd0, 24'h123456, CHK_NONE, NO_RESULT};
		directed[12] = '{ROW_PIXEL, CFG_WIDTH, 13'd0, 24'hABCDEF, CHK_ONE,
			'{11'd0, 12'd0, 8'd0, 1'b1, 1'b0}};
		directed[13] = '{ROW_PIXEL, CFG_WIDTH, 13'd0, 24'h5A5A5A, CHK_ONE,
			'{11'd0, 12'd1, 8'd0, 1'b1, 1'b0}};
		// 3x3 frame (width's top bit is dropped) with a saturating gradient.
		directed[14] = '{ROW_CONFIG, CFG_WIDTH, 13'h1003, 24'h0, CHK_NONE, NO_RESULT};
		directed[15] = '{ROW_CONFIG, CFG_HEIGHT, 13'd3, 24'h0, CHK_NONE, NO_RESULT};
		directed[16] = '{ROW_PIXEL, CFG_WIDTH, 13'd0, 24'h000000, CHK_PREDICT, NO_RESULT};
		directed[17] = '{ROW_PIXEL, CFG_WIDTH, 13'd0, 24'h3C7A10, CHK_PREDICT, NO_RESULT};
		directed[18] = '{ROW_PIXEL, CFG_WIDTH, 13'd0, 24'hFFFFFF, CHK_PREDICT, NO_RESULT};
		directed[19] = '{ROW_PIXEL, CFG_WIDTH, 13'd0, 24'h000000, CHK_PREDICT, NO_RESULT};
		directed[20] = '{ROW_PAUSE, CFG_WIDTH, 13'd0, 24'h0, CHK_NONE, NO_RESULT};
		directed[21] = '{ROW_PIXEL, CFG_WIDTH, 13'd0, 24'h80C040, CHK_PREDICT, NO_RESULT};
		directed[22] = '{ROW_PIXEL, CFG_WIDTH, 13'd0, 24'hFFFFFF, CHK_PREDICT, NO_RESULT};
		directed[23] = '{ROW_PIXEL, CFG_WIDTH, 13'd0, 24'h000000, CHK_PREDICT, NO_RESULT};
		directed[24] = '{ROW_PIXEL, CFG_WIDTH, 13'd0, 24'h0F1E2D, CHK_PREDICT, NO_RESULT};
		directed[25] = '{ROW_PIXEL, CFG_WIDTH, 13'd0, 24'hFFFFFF, CHK_PREDICT, NO_RESULT};

		// Known levels on every input from time zero.
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		cfg_valid <= 1'b0;
		cfg_addr  <= CFG_WIDTH;
		cfg_wdata <= '0;
		src_idle_pct  = 35;
		snk_stall_pct = 35;

		// Reset state of the behavioral image.
		reg_width  = WIDTH_RESET;
		reg_height = HEIGHT_RESET;
		col_pos = 0;
		row_pos = 0;
		for (i = 0; i < MAX_WIDTH; i++) begin
			line_upper[i] = '0;
			line_lower[i] = '0;
		end
		for (i = 0; i < 3; i++)
			for (j = 0; j < 3; j++)
				win[i][j] = '0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table.
		for (idx = 0; idx < DIR_ROWS; idx++) begin
			row_e = directed[idx];
			case (row_e.kind)
				ROW_CONFIG: write_reg(row_e.addr, row_e.value);
				ROW_PAUSE:  wait_drained();
				default:    send_pixel(row_e.pixel, row_e.chk, row_e.res);
			endcase
		end

		// Random frames, mostly small and complete, some cut short, a few at
		// the size extremes; idle pattern changes in four phases.
		rand_items = 0;
		while (rand_items < RANDOM_ITEMS) begin
			case (rand_items * 4 / RANDOM_ITEMS)
				0: begin
					src_idle_pct  = 0;
					snk_stall_pct = 0;
				end
				1: begin
					src_idle_pct  = 55;
					snk_stall_pct = 0;
				end
				2: begin
					src_idle_pct  = 0;
					snk_stall_pct = 55;
				end
				default: begin
					src_idle_pct  = 35;
					snk_stall_pct = 35;
				end
			endcase

			shape = $urandom_range(0, 9);
			if (shape == 0) begin
				// Wide single row.
				wv = 13'($urandom_range(2048, 4095)) | ($urandom_range(1) ? 13'h1000 : 13'h0);
				hv = 13'($urandom_range(1));
				write_reg(CFG_WIDTH, wv);
				write_reg(CFG_HEIGHT, hv);
				npix = $urandom_range(3, 16);
			end else if (shape == 1) begin
				// Tall narrow column.
				wv = 13'($urandom_range(0, 2));
				hv = 13'($urandom_range(4096, 8191));
				write_reg(CFG_HEIGHT, hv);
				write_reg(CFG_WIDTH, wv);
				npix = $urandom_range(3, 16);
			end else begin
				wv = 13'($urandom_range(0, 9)) | (($urandom_range(3) == 0) ? 13'h1000 : 13'h0);
				hv = 13'($urandom_range(0, 7));
				sel = $urandom_range(0, 2);
				if (sel != 1)
					write_reg(CFG_WIDTH, wv);
				if (sel != 0)
					write_reg(CFG_HEIGHT, hv);
				area = frame_width() * frame_height();
				if (area > 64)
					npix = $urandom_range(3, 20);
				else if ($urandom_range(3) == 0)
					npix = $urandom_range(1, area);
				else
					npix = area * $urandom_range(1, 2);
			end

			for (i = 0; i < npix; i++) begin
				if ($urandom_range(49) == 0)
					wait_drained();
				case ($urandom_range(9))
					0, 1:    px = '0;
					2, 3:    px = '1;
					default: px = 24'($urandom);
				endcase
				send_pixel(px, CHK_PREDICT, NO_RESULT);
				rand_items++;
			end
		end

		// Let everything owed arrive, then watch for stray results.
		wait_drained();
		s_tvalid <= 1'b0;
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("** sobel_edge_magnitude_unit: PASSED **");
		else
			$display("** sobel_edge_magnitude_unit: FAILED **");
		$finish;
	end

endmodule

// File: filelist.f
sv/sobel_pkg.sv
sv/sobel_isqrt.sv
sv/sobel_edge_magnitude_unit.sv
tb/tb_sobel_edge_magnitude_unit.sv
